FILE: hw/rtl/lowest_free_id_allocator_assert.svh
// assertion macros shared by the allocator rtl
// no dependencies; assertions drop out when SYNTH is defined
`ifndef LOWEST_FREE_ID_ALLOCATOR_ASSERT_SVH
`define LOWEST_FREE_ID_ALLOCATOR_ASSERT_SVH
`ifndef SYNTH
`define LFIA_ASSERT(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define LFIA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define LFIA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LFIA_ASSERT(lbl, clk, rst_n, cond, msg)
`define LFIA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define LFIA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/lfia_pkg.sv
// shared types and constants of the lowest free id allocator
// no dependencies
package lfia_pkg;

    localparam int unsigned MAX_IDS_DEF = 1024;

    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RECYCLE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_ROOT,
        S_RD_LAST,
        S_LD_VAL,
        S_RD_RIGHT,
        S_DN_STEP,
        S_UP_START,
        S_UP_STEP,
        S_WR_FINAL,
        S_EMIT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_RD_ROOT,
        OP_RD_LAST,
        OP_LD_VAL,
        OP_RD_RIGHT,
        OP_DN_STEP,
        OP_UP_START,
        OP_UP_STEP,
        OP_WR_FINAL,
        OP_EMIT
    } t_dp_op;

    typedef struct packed {
        logic heap_empty;
        logic hw_full;
        logic push_ok;
        logic one_left;
        logic dn_go;
        logic dn_more;
        logic up_go;
        logic up_more;
        logic pos_zero;
        logic out_full;
    } t_dp_stat;

endpackage

FILE: hw/rtl/lfia_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module lfia_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/lfia_dp.sv
// allocator datapath: heap ram, heap count, high-water counter, result register
// depends on lfia_pkg, lfia_ram and the assertion macro header
`include "lowest_free_id_allocator_assert.svh"

module lfia_dp #(
    parameter int unsigned MAX_IDS = lfia_pkg::MAX_IDS_DEF,
    localparam int unsigned ID_W = $clog2(MAX_IDS + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lfia_pkg::t_dp_op   i_op,
    input  logic               i_func,
    input  logic [ID_W-1:0]    i_rid,
    input  logic               i_m_tready,
    output lfia_pkg::t_dp_stat o_stat,
    output logic               o_out_valid,
    output logic [ID_W-1:0]    o_granted,
    output logic               o_exhausted
);
    import lfia_pkg::*;

    localparam int unsigned AW  = $clog2(MAX_IDS);
    localparam int unsigned CW  = ID_W;
    localparam int unsigned IXW = AW + 2;

    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_hw;
    logic [AW-1:0]   r_pos;
    logic [ID_W-1:0] r_val;
    logic [ID_W-1:0] r_top;
    logic            r_fail;
    logic [ID_W-1:0] r_lchild;
    logic            r_out_valid;
    logic [ID_W-1:0] r_granted;
    logic            r_exh;

    logic [ID_W-1:0] rd_data;
    logic [AW-1:0]   ram_raddr;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [ID_W-1:0] ram_wdata;

    logic [IXW-1:0]  left_ix;
    logic [IXW-1:0]  right_ix;
    logic [IXW-1:0]  count_ix;
    logic            right_ok;
    logic            pick_right;
    logic [ID_W-1:0] pick_val;
    logic [AW-1:0]   pick_pos;
    logic [IXW-1:0]  pick_left_ix;
    logic [AW-1:0]   parent_pos;
    logic [AW-1:0]   grand_pos;

    lfia_ram #(
        .WIDTH (ID_W),
        .DEPTH (MAX_IDS)
    ) u_heap_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd_data)
    );

    // child and parent positions of the current hole
    always_comb begin
        left_ix      = IXW'({r_pos, 1'b1});
        right_ix     = IXW'({r_pos, 1'b0}) + IXW'(2);
        count_ix     = IXW'(r_count);
        right_ok     = right_ix < count_ix;
        pick_right   = right_ok && (rd_data < r_lchild);
        pick_val     = pick_right ? rd_data : r_lchild;
        pick_pos     = pick_right ? right_ix[AW-1:0] : left_ix[AW-1:0];
        pick_left_ix = IXW'({pick_pos, 1'b1});
        parent_pos   = AW'((r_pos - AW'(1)) >> 1);
        grand_pos    = AW'((parent_pos - AW'(1)) >> 1);
    end

    always_comb begin
        o_stat.heap_empty = (r_count == '0);
        o_stat.hw_full    = (r_hw == CW'(MAX_IDS));
        o_stat.push_ok    = (i_rid != '0) && (i_rid <= ID_W'(MAX_IDS))
                            && (r_count < CW'(MAX_IDS));
        o_stat.one_left   = (r_count > CW'(1));
        o_stat.dn_go      = (pick_val < r_val);
        o_stat.dn_more    = (pick_left_ix < count_ix);
        o_stat.up_go      = (rd_data > r_val);
        o_stat.up_more    = (parent_pos != '0);
        o_stat.pos_zero   = (r_pos == '0);
        o_stat.out_full   = r_out_valid;
    end

    always_comb begin
        ram_raddr = '0;
        ram_we    = 1'b0;
        ram_waddr = r_pos;
        ram_wdata = r_val;
        case (i_op)
            OP_RD_ROOT:  ram_raddr = '0;
            OP_RD_LAST:  ram_raddr = r_count[AW-1:0];
            OP_LD_VAL:   ram_raddr = AW'(1);
            OP_RD_RIGHT: ram_raddr = right_ix[AW-1:0];
            OP_DN_STEP: begin
                ram_raddr = pick_left_ix[AW-1:0];
                ram_we    = o_stat.dn_go;
                ram_wdata = pick_val;
            end
            OP_UP_START: ram_raddr = parent_pos;
            OP_UP_STEP: begin
                ram_raddr = grand_pos;
                ram_we    = o_stat.up_go;
                ram_wdata = rd_data;
            end
            OP_WR_FINAL: ram_we = 1'b1;
            default:     ram_raddr = '0;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_hw        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_op == OP_ACCEPT) begin
                if (i_func == FUNC_RECYCLE) begin
                    if (o_stat.push_ok) begin
                        r_count <= r_count + CW'(1);
                    end
                end else if (!o_stat.heap_empty) begin
                    r_count <= r_count - CW'(1);
                end else if (!o_stat.hw_full) begin
                    r_hw <= r_hw + CW'(1);
                end
            end
            if (i_op == OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_ACCEPT: begin
                if (i_func == FUNC_RECYCLE) begin
                    r_val <= i_rid;
                    r_pos <= r_count[AW-1:0];
                end else if (!o_stat.heap_empty) begin
                    r_fail <= 1'b0;
                end else if (o_stat.hw_full) begin
                    r_top  <= '0;
                    r_fail <= 1'b1;
                end else begin
                    r_top  <= r_hw + CW'(1);
                    r_fail <= 1'b0;
                end
            end
            OP_RD_LAST:  r_top <= rd_data;
            OP_LD_VAL: begin
                r_val <= rd_data;
                r_pos <= '0;
            end
            OP_RD_RIGHT: r_lchild <= rd_data;
            OP_DN_STEP: begin
                if (o_stat.dn_go) begin
                    r_pos <= pick_pos;
                end
            end
            OP_UP_STEP: begin
                if (o_stat.up_go) begin
                    r_pos <= parent_pos;
                end
            end
            OP_EMIT: begin
                r_granted <= r_top;
                r_exh     <= r_fail;
            end
            default: r_pos <= r_pos;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_granted   = r_granted;
    assign o_exhausted = r_exh;

    `LFIA_ASSERT(a_count_cap, i_clk, i_rst_n, r_count <= CW'(MAX_IDS), "heap count above capacity")
    `LFIA_ASSERT(a_hw_cap, i_clk, i_rst_n, r_hw <= CW'(MAX_IDS), "high water above capacity")
    `LFIA_ASSERT_IMP(a_emit_room, i_clk, i_rst_n, i_op == OP_EMIT, !r_out_valid || i_m_tready, "result overwrites pending word")

endmodule

FILE: hw/rtl/lfia_ctrl.sv
// allocator controller: sequences accept, pop sift-down, push sift-up and emit
// depends on lfia_pkg and the assertion macro header
`include "lowest_free_id_allocator_assert.svh"

module lfia_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_valid,
    input  logic               i_func,
    input  logic               i_m_tready,
    input  lfia_pkg::t_dp_stat i_stat,
    output logic               o_s_ready,
    output lfia_pkg::t_dp_op   o_op
);
    import lfia_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_result;
    logic   n_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_result <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_result <= n_result;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_result  = r_result;
        o_s_ready = 1'b0;
        o_op      = OP_NONE;
        case (r_state)
            S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_op = OP_ACCEPT;
                    if (i_func == FUNC_RECYCLE) begin
                        n_result = 1'b0;
                        if (i_stat.push_ok) begin
                            n_state = S_UP_START;
                        end
                    end else begin
                        n_result = 1'b1;
                        n_state  = i_stat.heap_empty ? S_EMIT : S_RD_ROOT;
                    end
                end
            end
            S_RD_ROOT: begin
                o_op    = OP_RD_ROOT;
                n_state = S_RD_LAST;
            end
            S_RD_LAST: begin
                o_op    = OP_RD_LAST;
                n_state = S_LD_VAL;
            end
            S_LD_VAL: begin
                o_op    = OP_LD_VAL;
                n_state = i_stat.one_left ? S_RD_RIGHT : S_WR_FINAL;
            end
            S_RD_RIGHT: begin
                o_op    = OP_RD_RIGHT;
                n_state = S_DN_STEP;
            end
            S_DN_STEP: begin
                o_op    = OP_DN_STEP;
                n_state = (i_stat.dn_go && i_stat.dn_more) ? S_RD_RIGHT : S_WR_FINAL;
            end
            S_UP_START: begin
                o_op    = OP_UP_START;
                n_state = i_stat.pos_zero ? S_WR_FINAL : S_UP_STEP;
            end
            S_UP_STEP: begin
                o_op    = OP_UP_STEP;
                n_state = (i_stat.up_go && i_stat.up_more) ? S_UP_STEP : S_WR_FINAL;
            end
            S_WR_FINAL: begin
                o_op    = OP_WR_FINAL;
                n_state = r_result ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (!i_stat.out_full || i_m_tready) begin
                    o_op    = OP_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    `LFIA_ASSERT_NXT(a_push_start, i_clk, i_rst_n, r_state == S_IDLE && i_s_valid && i_func == FUNC_RECYCLE && i_stat.push_ok, r_state == S_UP_START, "push did not start sift-up")
    `LFIA_ASSERT_IMP(a_pop_result, i_clk, i_rst_n, r_state == S_RD_RIGHT || r_state == S_DN_STEP || r_state == S_EMIT, r_result, "allocate path without result")
    `LFIA_ASSERT_IMP(a_push_quiet, i_clk, i_rst_n, r_state == S_UP_START || r_state == S_UP_STEP, !r_result, "push path marked with result")

endmodule

FILE: hw/rtl/lowest_free_id_allocator.sv
// top level of the lowest free id allocator: controller plus datapath with heap ram
// depends on lfia_pkg, lfia_ctrl and lfia_dp
//
// channel   dir  tdata                        tuser
// s_axis    in   [ID_W-1:0] recycled_id       [0] func (0 allocate, 1 recycle)
// m_axis    out  [ID_W-1:0] granted_id        [0] exhausted
//
// allocate from heap: read root and last entry, then a right-child read and a sift-down step per child compare
// recycle: a sift-up step per parent compare, dropped when invalid or heap full; fresh or failed allocate: emit
// the heap ram has a single read port, so one child is read per cycle
// reset is synchronous; heap entries at or past the count are never used, so no clearing pass
// one output register: a new word is taken while a result waits, an allocate that
// finishes while the register is still full holds until it drains
module lowest_free_id_allocator #(
    parameter int unsigned MAX_IDS = lfia_pkg::MAX_IDS_DEF,
    localparam int unsigned ID_W = $clog2(MAX_IDS + 1),
    localparam int unsigned TDATA_W = ((ID_W + 7) / 8) * 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [TDATA_W-1:0] i_s_axis_tdata,   // recycled_id
    input  logic               i_s_axis_tuser,   // func
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [TDATA_W-1:0] o_m_axis_tdata,   // granted_id
    output logic               o_m_axis_tuser    // exhausted
);
    import lfia_pkg::*;

    t_dp_op          op;
    t_dp_stat        stat;
    logic [ID_W-1:0] granted;

    lfia_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_valid  (i_s_axis_tvalid),
        .i_func     (i_s_axis_tuser),
        .i_m_tready (i_m_axis_tready),
        .i_stat     (stat),
        .o_s_ready  (o_s_axis_tready),
        .o_op       (op)
    );

    lfia_dp #(
        .MAX_IDS (MAX_IDS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .i_func      (i_s_axis_tuser),
        .i_rid       (i_s_axis_tdata[ID_W-1:0]),
        .i_m_tready  (i_m_axis_tready),
        .o_stat      (stat),
        .o_out_valid (o_m_axis_tvalid),
        .o_granted   (granted),
        .o_exhausted (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = TDATA_W'(granted);

endmodule

FILE: test/lowest_free_id_allocator_tb.sv
// self-checking testbench for the lowest free id allocator: random and directed words,
// a min-heap predictor of granted ids, random stalls on both streams
// depends on lfia_pkg and lowest_free_id_allocator
module lowest_free_id_allocator_tb;
    import lfia_pkg::*;

    localparam int unsigned MAX_IDS = MAX_IDS_DEF;
    localparam int unsigned ID_W = $clog2(MAX_IDS + 1);
    localparam int unsigned TDATA_W = ((ID_W + 7) / 8) * 8;
    localparam int TIMEOUT = 5_000_000;
    localparam int TAIL_CYCLES = 40;

    typedef struct {
        bit             drain;
        logic           func;
        logic [ID_W-1:0] id;
    } t_req_word;

    typedef struct {
        logic [ID_W-1:0] granted;
        logic            exhausted;
    } t_grant;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               i_s_axis_tvalid = 1'b0;
    logic               o_s_axis_tready;
    logic [TDATA_W-1:0] i_s_axis_tdata = '0;  // recycled_id
    logic               i_s_axis_tuser = 1'b0;  // func
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] o_m_axis_tdata;  // granted_id
    logic               o_m_axis_tuser;  // exhausted

    t_req_word       words_to_send[$];
    t_grant          grants_due[$];
    logic [ID_W-1:0] free_heap[0:MAX_IDS-1];
    int unsigned     free_count = 0;
    int unsigned     fresh_hw = 0;
    int              mismatches = 0;
    int              results_seen = 0;

    t_req_word cur_word;
    bit        offering = 1'b0;
    bit        word_taken = 1'b0;
    int        send_gap = 0;
    int        send_calm = 0;
    int        take_gap = 0;
    int        take_calm = 0;
    int        hold_left = 0;
    bit        hold_done = 1'b0;

    lowest_free_id_allocator #(.MAX_IDS(MAX_IDS)) dut (.*);

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // mostly short gaps, a few long ones, and runs without any
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void heap_push(logic [ID_W-1:0] id);
        int unsigned pos;
        int unsigned par;
        logic [ID_W-1:0] t;
        pos = free_count;
        free_heap[pos] = id;
        free_count++;
        while (pos != 0) begin
            par = (pos - 1) / 2;
            if (free_heap[par] > free_heap[pos]) begin
                t = free_heap[par];
                free_heap[par] = free_heap[pos];
                free_heap[pos] = t;
                pos = par;
            end else begin
                break;
            end
        end
    endfunction

    function automatic logic [ID_W-1:0] heap_pop();
        logic [ID_W-1:0] top;
        logic [ID_W-1:0] t;
        int unsigned pos;
        int unsigned lc;
        int unsigned pick;
        top = free_heap[0];
        pos = 0;
        free_count--;
        free_heap[0] = free_heap[free_count];
        forever begin
            lc = 2 * pos + 1;
            if (lc >= free_count) break;
            pick = lc;
            // ties go to the left child
            if (lc + 1 < free_count && free_heap[lc + 1] < free_heap[lc]) pick = lc + 1;
            if (free_heap[pick] < free_heap[pos]) begin
                t = free_heap[pick];
                free_heap[pick] = free_heap[pos];
                free_heap[pos] = t;
                pos = pick;
            end else begin
                break;
            end
        end
        return top;
    endfunction

    function automatic void predict_grant(logic func, logic [ID_W-1:0] id);
        t_grant g;
        if (func == FUNC_RECYCLE) begin
            if (id != 0 && id <= MAX_IDS && free_count < MAX_IDS) heap_push(id);
            return;
        end
        g.granted = '0;
        g.exhausted = 1'b0;
        if (free_count > 0) begin
            g.granted = heap_pop();
        end else if (fresh_hw >= MAX_IDS) begin
            g.exhausted = 1'b1;
        end else begin
            fresh_hw++;
            g.granted = ID_W'(fresh_hw);
        end
        grants_due = {grants_due, g};
    endfunction

    function automatic void queue_alloc();
        t_req_word w;
        w.drain = 1'b0;
        w.func = FUNC_ALLOC;
        w.id = ID_W'($urandom);
        words_to_send = {words_to_send, w};
    endfunction

    function automatic void queue_recycle(int unsigned id);
        t_req_word w;
        w.drain = 1'b0;
        w.func = FUNC_RECYCLE;
        w.id = ID_W'(id);
        words_to_send = {words_to_send, w};
    endfunction

    function automatic void queue_drain();
        t_req_word w;
        w.drain = 1'b1;
        w.func = FUNC_ALLOC;
        w.id = '0;
        words_to_send = {words_to_send, w};
    endfunction

    // sender side
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            predict_grant(i_s_axis_tuser, i_s_axis_tdata[ID_W-1:0]);
            word_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (word_taken) begin
                word_taken = 1'b0;
                offering = 1'b0;
                send_gap = pick_gap(send_calm);
            end
            if (!offering) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (words_to_send.size() > 0) begin
                    if (words_to_send[0].drain) begin
                        if (grants_due.size() == 0) void'(words_to_send.pop_front());
                    end else begin
                        cur_word = words_to_send.pop_front();
                        offering = 1'b1;
                    end
                end
            end
        end
        i_s_axis_tvalid <= offering;
        i_s_axis_tdata <= TDATA_W'(cur_word.id);
        i_s_axis_tuser <= cur_word.func;
    end

    // receiver side
    always @(posedge i_clk) begin
        t_grant want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            if (grants_due.size() == 0) begin
                $display("%0t: unexpected word granted_id %0d exhausted %0b",
                         $time, o_m_axis_tdata, o_m_axis_tuser);
                mismatches++;
            end else begin
                want = grants_due.pop_front();
                if (o_m_axis_tdata !== TDATA_W'(want.granted)) begin
                    $display("%0t: granted_id expected %0d actual %0d",
                             $time, want.granted, o_m_axis_tdata);
                    mismatches++;
                end
                if (o_m_axis_tuser !== want.exhausted) begin
                    $display("%0t: exhausted expected %0b actual %0b",
                             $time, want.exhausted, o_m_axis_tuser);
                    mismatches++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        logic rdy;
        rdy = 1'b0;
        if (i_rst_n) begin
            // one long hold-off early on so the block backs up into its input
            if (!hold_done && results_seen >= 50) begin
                hold_done = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
            end else if (take_gap > 0) begin
                take_gap--;
            end else begin
                rdy = 1'b1;
                take_gap = pick_gap(take_calm);
            end
        end
        i_m_axis_tready <= rdy;
    end

    initial begin
        #(TIMEOUT);
        $display("lowest_free_id_allocator verification failed");
        $finish;
    end

    initial begin
        int r;

        // fresh id, ignored ids, duplicates, pop down to an empty heap
        queue_alloc();
        queue_recycle(0);
        queue_recycle(2047);
        queue_recycle(1025);
        queue_recycle(MAX_IDS);
        queue_recycle(5);
        queue_recycle(5);
        queue_recycle(3);
        repeat (5) queue_alloc();
        // equal children on the sift-down
        queue_recycle(1);
        queue_recycle(6);
        queue_recycle(6);
        queue_recycle(9);
        repeat (4) queue_alloc();
        queue_drain();

        // mostly fresh ids with a few small recycled ones
        for (int i = 0; i < 100; i++) begin
            if ($urandom_range(0, 4) == 0) queue_recycle($urandom_range(1, 32));
            else queue_alloc();
        end
        queue_drain();

        // fill the heap past full, then pop and push around a full heap
        for (int i = 0; i < MAX_IDS + 6; i++) queue_recycle($urandom_range(1, MAX_IDS));
        for (int i = 0; i < 60; i++) begin
            r = $urandom_range(0, 99);
            if (r < 75) queue_alloc();
            else if (r < 92) queue_recycle($urandom_range(1, MAX_IDS));
            else if (r < 96) queue_recycle(0);
            else queue_recycle($urandom_range(MAX_IDS + 1, 2047));
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (words_to_send.size() != 0 || offering || grants_due.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (grants_due.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, grants_due.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("lowest_free_id_allocator verification clean");
        end else begin
            $display("lowest_free_id_allocator verification failed");
        end
        $finish;
    end

endmodule
